FILE: design/ocps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the output chase pattern sequencer.
// No dependencies; imported by every module of the block.
package ocps_pkg;

    // Mode codes as they appear on the input channel.
    localparam logic [3:0] MODE_OFF     = 4'd0;
    localparam logic [3:0] MODE_RAW     = 4'd1;
    localparam logic [3:0] MODE_UP      = 4'd2;
    localparam logic [3:0] MODE_DOWN    = 4'd3;
    localparam logic [3:0] MODE_UPDOWN  = 4'd4;
    localparam logic [3:0] MODE_DOWNUP  = 4'd5;
    localparam logic [3:0] MODE_IN      = 4'd6;
    localparam logic [3:0] MODE_OUT     = 4'd7;
    localparam logic [3:0] MODE_INOUT   = 4'd8;
    localparam logic [3:0] MODE_OUTIN   = 4'd9;
    localparam logic [3:0] MODE_ALL     = 4'd10;
    localparam logic [3:0] MODE_ALT     = 4'd11;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MIN_FIRE = 2'd0;
    localparam logic [1:0] CFG_MAX_FIRE = 2'd1;
    localparam logic [1:0] CFG_MIN_REST = 2'd2;
    localparam logic [1:0] CFG_MAX_REST = 2'd3;

    localparam logic [15:0] RST_MIN_FIRE = 16'd20;
    localparam logic [15:0] RST_MAX_FIRE = 16'd2000;
    localparam logic [15:0] RST_MIN_REST = 16'd20;
    localparam logic [15:0] RST_MAX_REST = 16'd5000;

    localparam logic [15:0] PAT_ALL  = 16'hFFFF;
    localparam logic [15:0] PAT_EVEN = 16'h5555;
    localparam logic [15:0] PAT_ODD  = 16'hAAAA;

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic [1:0] {
        KIND_OFF,
        KIND_RAW,
        KIND_CHASE
    } t_kind;

    typedef struct packed {
        logic [2:0] first;
        logic [2:0] last;
        logic       backward;
        logic       mirrored;
        logic       bounce;
    } t_chase;

    typedef struct packed {
        logic [15:0] min_fire;
        logic [15:0] max_fire;
        logic [15:0] min_rest;
        logic [15:0] max_rest;
    } t_cfg;

    // One classified tick as it travels from front to back.
    typedef struct packed {
        logic [3:0]  mode;
        t_kind       kind;
        t_chase      chase;
        logic [15:0] trig;
        logic        rep;
        logic [15:0] fire;
        logic [15:0] rest;
        logic [31:0] now;
    } t_item;

endpackage

FILE: design/output_chase_pattern_sequencer.sv
`timescale 1ns / 1ps
// Output chase pattern sequencer: top level with configuration registers.
// Depends on ocps_pkg, ocps_front, ocps_queue, ocps_back.
//
// Usage:
//   Each transaction on the input channel (i_in_valid / o_in_ready) is one
//   update tick: mode, trigger mask, repeat flag, fire and rest durations,
//   tempo rate and the current time in ms. Each tick yields exactly one fire
//   mask transaction on the output channel (o_out_valid / i_out_ready).
//   Configuration (clamp bounds) is written through i_cfg_we / i_cfg_index /
//   i_cfg_data, one register per cycle; the user must write it only while
//   the block is idle, which the block itself does not enforce.
// Pipeline and throughput:
//   An accepted tick is registered in the front stage, which clamps and
//   classifies; the rest time is tempo-scaled on the way into the queue,
//   and the back end computes the new state and registers the mask on the
//   pop. Throughput is one tick per cycle when the output is not stalled,
//   bounded by the back end, which updates its state on every pop.
//
// Reset (synchronous, active low) restores the clamp defaults, returns to
// off mode and empties the pipeline. When the receiver stalls the mask is
// held; the front keeps accepting until the four-entry queue and the front
// stage are full, then drops o_in_ready.
module output_chase_pattern_sequencer import ocps_pkg::*; #(
    parameter int NUM_OUTPUTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_mode,
    input  logic [15:0] i_trigger_mask,
    input  logic        i_repeat_req,
    input  logic [15:0] i_fire_ms,
    input  logic [15:0] i_rest_ms,
    input  logic [7:0]  i_rate,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_fire_mask
);

    t_cfg  r_cfg;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;
    t_item f_item;
    t_item q_item;

    // Clamp bound registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_fire <= RST_MIN_FIRE;
            r_cfg.max_fire <= RST_MAX_FIRE;
            r_cfg.min_rest <= RST_MIN_REST;
            r_cfg.max_rest <= RST_MAX_REST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_FIRE: r_cfg.min_fire <= i_cfg_data;
                CFG_MAX_FIRE: r_cfg.max_fire <= i_cfg_data;
                CFG_MIN_REST: r_cfg.min_rest <= i_cfg_data;
                CFG_MAX_REST: r_cfg.max_rest <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: accept, classify, clamp and scale.
    ocps_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_trigger_mask (i_trigger_mask),
        .i_repeat_req   (i_repeat_req),
        .i_fire_ms      (i_fire_ms),
        .i_rest_ms      (i_rest_ms),
        .i_rate         (i_rate),
        .i_now_ms       (i_now_ms),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_item         (f_item)
    );

    // Decoupling queue.
    ocps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    // Back: sequencer state and output register.
    ocps_back #(
        .NUM_OUTPUTS (NUM_OUTPUTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_item      (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_fire_mask (o_fire_mask)
    );

endmodule

FILE: design/ocps_front.sv
`timescale 1ns / 1ps
// Front end: accepts ticks, classifies the mode, clamps and tempo-scales durations.
// Depends on ocps_pkg.
module ocps_front import ocps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_mode,
    input  logic [15:0] i_trigger_mask,
    input  logic        i_repeat_req,
    input  logic [15:0] i_fire_ms,
    input  logic [15:0] i_rest_ms,
    input  logic [7:0]  i_rate,
    input  logic [31:0] i_now_ms,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    function automatic logic [15:0] clamp16(input logic [15:0] v, input logic [15:0] lo,
                                            input logic [15:0] hi);
        if (v < lo)      return lo;
        else if (v > hi) return hi;
        else             return v;
    endfunction

    function automatic t_chase chase_of(input logic [3:0] mode);
        t_chase c;
        c = '0;
        unique case (mode)
            MODE_UP:     c = '{3'd0, 3'd7, 1'b0, 1'b0, 1'b0};
            MODE_DOWN:   c = '{3'd7, 3'd0, 1'b1, 1'b0, 1'b0};
            MODE_UPDOWN: c = '{3'd0, 3'd7, 1'b0, 1'b0, 1'b1};
            MODE_DOWNUP: c = '{3'd7, 3'd0, 1'b1, 1'b0, 1'b1};
            MODE_IN:     c = '{3'd0, 3'd3, 1'b0, 1'b1, 1'b0};
            MODE_OUT:    c = '{3'd3, 3'd0, 1'b1, 1'b1, 1'b0};
            MODE_INOUT:  c = '{3'd0, 3'd3, 1'b0, 1'b1, 1'b1};
            MODE_OUTIN:  c = '{3'd3, 3'd0, 1'b1, 1'b1, 1'b1};
            MODE_ALT:    c = '{3'd0, 3'd1, 1'b0, 1'b0, 1'b0};
            default:     c = '0;
        endcase
        return c;
    endfunction

    // Stage 1: clamp and classify.
    logic        r_s1_valid;
    t_item       r_s1;
    logic [7:0]  r_s1_rate;
    logic        s1_adv;
    t_kind       kind;

    // After stage 1: combinational tempo scale of the rest time.
    logic [24:0] prod;
    logic [17:0] scaled;
    logic [15:0] sat;

    assign o_push     = r_s1_valid && !i_q_full;
    assign s1_adv     = !r_s1_valid || !i_q_full;
    assign o_in_ready = s1_adv;

    always_comb begin
        if (i_mode == MODE_RAW)                          kind = KIND_RAW;
        else if (i_mode >= MODE_UP && i_mode <= MODE_ALT) kind = KIND_CHASE;
        else                                              kind = KIND_OFF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= i_in_valid;
        end
        if (s1_adv && i_in_valid) begin
            r_s1.mode  <= i_mode;
            r_s1.kind  <= kind;
            r_s1.chase <= chase_of(i_mode);
            r_s1.trig  <= i_trigger_mask;
            r_s1.rep   <= i_repeat_req;
            r_s1.fire  <= clamp16(i_fire_ms, i_cfg.min_fire, i_cfg.max_fire);
            r_s1.rest  <= clamp16(i_rest_ms, i_cfg.min_rest, i_cfg.max_rest);
            r_s1.now   <= i_now_ms;
            r_s1_rate  <= i_rate;
        end
    end

    always_comb begin
        prod   = 25'(r_s1.rest) * 25'(9'd256 - {1'b0, r_s1_rate});
        scaled = prod[24:7];
        sat    = (scaled > 18'h0FFFF) ? 16'hFFFF : scaled[15:0];
        o_item      = r_s1;
        o_item.rest = clamp16(sat, i_cfg.min_rest, i_cfg.max_rest);
    end

endmodule

FILE: design/ocps_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified ticks between front and back.
// Depends on ocps_pkg.
module ocps_queue import ocps_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
        if (i_push) r_mem[r_wr] <= i_item;
    end

endmodule

FILE: design/ocps_back.sv
`timescale 1ns / 1ps
// Back end: chase sequencer, per-output raw lanes and the output register.
// Depends on ocps_pkg.
module ocps_back import ocps_pkg::*; #(
    parameter int NUM_OUTPUTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_fire_mask
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRE,
        PH_REST,
        PH_DONE
    } t_phase;

    function automatic logic reached(input logic [31:0] dl, input logic [31:0] now);
        logic [31:0] d;
        d = now - dl;
        return !d[31];
    endfunction

    function automatic logic [2:0] step_move(input logic [2:0] idx, input logic back);
        return back ? idx - 3'd1 : idx + 3'd1;
    endfunction

    logic                   r_out_valid;
    logic [15:0]            r_mask;
    logic [3:0]             r_mode;
    t_phase                 r_phase;
    logic [2:0]             r_step;
    logic                   r_back;
    logic [31:0]            r_deadline;
    logic [NUM_OUTPUTS-1:0] r_firing;
    logic [NUM_OUTPUTS-1:0] r_need_rel;
    logic [31:0]            r_fire_dl [NUM_OUTPUTS];
    logic [31:0]            r_rest_dl [NUM_OUTPUTS];

    logic                   n_out_valid;
    logic [15:0]            n_mask;
    t_phase                 n_phase;
    logic [2:0]             n_step;
    logic                   n_back;
    logic [31:0]            n_deadline;
    logic [NUM_OUTPUTS-1:0] n_firing;
    logic [NUM_OUTPUTS-1:0] n_need_rel;
    logic [31:0]            n_fire_dl [NUM_OUTPUTS];
    logic [31:0]            n_rest_dl [NUM_OUTPUTS];

    logic   clr;
    t_phase ph0;
    logic   go;
    t_chase c;
    logic [15:0] pat;

    assign o_pop       = !i_empty && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_fire_mask = r_mask;
    assign clr         = (i_item.mode != r_mode);
    assign ph0         = clr ? PH_IDLE : r_phase;
    assign c           = i_item.chase;

    // Raw lanes: every output on its own, in parallel.
    always_comb begin
        for (int i = 0; i < NUM_OUTPUTS; i++) begin
            logic want;
            logic f0;
            logic nr0;
            logic [31:0] fd0;
            logic [31:0] rd0;
            want = i_item.trig[i];
            f0   = clr ? 1'b0 : r_firing[i];
            nr0  = clr ? 1'b0 : r_need_rel[i];
            fd0  = clr ? 32'd0 : r_fire_dl[i];
            rd0  = clr ? 32'd0 : r_rest_dl[i];
            n_firing[i]   = f0;
            n_need_rel[i] = nr0;
            n_fire_dl[i]  = fd0;
            n_rest_dl[i]  = rd0;
            if (i_item.kind == KIND_RAW) begin
                if (f0) begin
                    if (!want || reached(fd0, i_item.now)) begin
                        n_firing[i]  = 1'b0;
                        n_rest_dl[i] = i_item.now + {16'd0, i_item.rest};
                        if (want && !i_item.rep) n_need_rel[i] = 1'b1;
                    end
                end else if (!want) begin
                    n_need_rel[i] = 1'b0;
                end else if (!nr0 && reached(rd0, i_item.now)) begin
                    n_firing[i]  = 1'b1;
                    n_fire_dl[i] = i_item.now + {16'd0, i_item.fire};
                end
            end
        end
    end

    // Chase sequencer.
    always_comb begin
        n_phase    = ph0;
        n_step     = r_step;
        n_back     = r_back;
        n_deadline = r_deadline;
        go         = 1'b0;
        if (i_item.kind == KIND_CHASE) begin
            unique case (ph0)
                PH_IDLE: begin
                    n_step = c.first;
                    n_back = c.backward;
                    go     = 1'b1;
                end
                PH_FIRE: begin
                    if (reached(r_deadline, i_item.now)) begin
                        n_phase    = PH_REST;
                        n_deadline = i_item.now + {16'd0, i_item.rest};
                    end
                end
                PH_REST: begin
                    if (reached(r_deadline, i_item.now)) begin
                        go = 1'b1;
                        priority if (!c.bounce) begin
                            if (r_step == c.last) begin
                                if (!i_item.rep) begin
                                    n_phase = PH_DONE;
                                    go      = 1'b0;
                                end
                                n_step = c.first;
                            end else begin
                                n_step = step_move(r_step, r_back);
                            end
                        end else if (r_step == c.last && r_back == c.backward) begin
                            n_back = !c.backward;
                            n_step = step_move(r_step, !c.backward);
                        end else if (r_step == c.first && r_back != c.backward) begin
                            if (!i_item.rep) begin
                                n_phase = PH_DONE;
                                go      = 1'b0;
                            end else begin
                                n_back = c.backward;
                                n_step = step_move(r_step, c.backward);
                            end
                        end else begin
                            n_step = step_move(r_step, r_back);
                        end
                        // hold the index on a one-shot end
                        if (!go) begin
                            n_step = r_step;
                            n_back = r_back;
                        end
                    end
                end
                PH_DONE: begin
                    if (i_item.rep) begin
                        n_step = c.first;
                        n_back = c.backward;
                        go     = 1'b1;
                    end
                end
                default: ;
            endcase
            if (go) begin
                n_phase    = PH_FIRE;
                n_deadline = i_item.now + {16'd0, i_item.fire};
            end
        end
    end

    always_comb begin
        if (i_item.mode == MODE_ALL)      pat = PAT_ALL;
        else if (i_item.mode == MODE_ALT) pat = (n_step != 3'd0) ? PAT_ODD : PAT_EVEN;
        else begin
            pat = 16'd1 << n_step;
            if (c.mirrored) pat = pat | (16'd1 << (3'd7 - n_step));
        end
        n_mask = '0;
        unique case (i_item.kind)
            KIND_RAW: begin
                for (int i = 0; i < NUM_OUTPUTS; i++) n_mask[i] = n_firing[i];
            end
            KIND_CHASE: n_mask = (n_phase == PH_FIRE) ? (pat & i_item.trig) : 16'd0;
            default:    n_mask = '0;
        endcase
        n_out_valid = o_pop || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_mode      <= MODE_OFF;
            r_phase     <= PH_IDLE;
            r_step      <= '0;
            r_back      <= 1'b0;
            r_deadline  <= '0;
            r_firing    <= '0;
            r_need_rel  <= '0;
            for (int i = 0; i < NUM_OUTPUTS; i++) begin
                r_fire_dl[i] <= '0;
                r_rest_dl[i] <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_mode     <= i_item.mode;
                r_phase    <= n_phase;
                r_step     <= n_step;
                r_back     <= n_back;
                r_deadline <= n_deadline;
                r_firing   <= n_firing;
                r_need_rel <= n_need_rel;
                for (int i = 0; i < NUM_OUTPUTS; i++) begin
                    r_fire_dl[i] <= n_fire_dl[i];
                    r_rest_dl[i] <= n_rest_dl[i];
                end
            end
        end
        if (o_pop) r_mask <= n_mask;
    end

endmodule

FILE: design/ocps_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the output chase pattern sequencer, with its bind.
// Depends on output_chase_pattern_sequencer.
module ocps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_fire_mask
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_fire_mask))
        else $error("stalled fire mask changed or dropped");

    // Reset empties the pipeline.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present right after reset");

    // The front is ready right after reset.
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

    // No result can appear in the cycle after an idle start from an empty pipeline.
    a_no_invent: assert property (@(posedge i_clk)
        !i_rst_n ##1 !i_in_valid |=> !o_out_valid)
        else $error("result without a transaction");

endmodule

bind output_chase_pattern_sequencer ocps_checker u_ocps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_fire_mask (o_fire_mask)
);

FILE: test/ocps_tb_pkg.sv
`timescale 1ns / 1ps
// Tick record and fire-mask scoreboard for the chase sequencer testbench.
// Depends on ocps_pkg for mode codes, register indexes, chase shapes and patterns.
package ocps_tb_pkg;
    import ocps_pkg::*;

    localparam int N_OUT = 8;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRE,
        PH_REST,
        PH_DONE
    } run_phase_t;

    // One update tick as offered on the input channel.
    typedef struct packed {
        logic [3:0]  mode;
        logic [15:0] trig;
        logic        rep;
        logic [15:0] fire_ms;
        logic [15:0] rest_ms;
        logic [7:0]  rate;
        logic [31:0] now_ms;
    } tick_t;

    // Inverted bounds fall through as is: low wins when below, else high.
    function automatic logic [15:0] clamp_ms(logic [31:0] v, logic [15:0] lo, logic [15:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v[15:0];
    endfunction

    function automatic bit deadline_hit(logic [31:0] dl, logic [31:0] now);
        logic [31:0] diff;
        diff = now - dl;
        return diff[31] == 1'b0;
    endfunction

    function automatic t_chase chase_of(logic [3:0] mode);
        t_chase c;
        c = '0;
        case (mode)
            MODE_UP:     c.last = 3'd7;
            MODE_DOWN:   begin c.first = 3'd7; c.backward = 1'b1; end
            MODE_UPDOWN: begin c.last = 3'd7; c.bounce = 1'b1; end
            MODE_DOWNUP: begin c.first = 3'd7; c.backward = 1'b1; c.bounce = 1'b1; end
            MODE_IN:     begin c.last = 3'd3; c.mirrored = 1'b1; end
            MODE_OUT:    begin c.first = 3'd3; c.backward = 1'b1; c.mirrored = 1'b1; end
            MODE_INOUT:  begin c.last = 3'd3; c.mirrored = 1'b1; c.bounce = 1'b1; end
            MODE_OUTIN:  begin
                c.first = 3'd3; c.backward = 1'b1; c.mirrored = 1'b1; c.bounce = 1'b1;
            end
            MODE_ALT:    c.last = 3'd1;
            default:     c = '0;
        endcase
        return c;
    endfunction

    class fire_mask_board;
        logic [15:0] min_fire, max_fire, min_rest, max_rest;
        logic [3:0]  cur_mode;
        run_phase_t  phase;
        logic [2:0]  step_idx;
        logic        step_back;
        logic [31:0] phase_dl;
        logic [N_OUT-1:0] raw_firing;
        logic [N_OUT-1:0] raw_hold;
        logic [31:0] raw_fire_dl [N_OUT];
        logic [31:0] raw_rest_dl [N_OUT];
        logic [15:0] expected_masks [$];
        int errors;

        function new();
            min_fire  = RST_MIN_FIRE;
            max_fire  = RST_MAX_FIRE;
            min_rest  = RST_MIN_REST;
            max_rest  = RST_MAX_REST;
            cur_mode  = MODE_OFF;
            step_idx  = '0;
            step_back = 1'b0;
            phase_dl  = '0;
            errors    = 0;
            clear_run();
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_MIN_FIRE: min_fire = val;
                CFG_MAX_FIRE: max_fire = val;
                CFG_MIN_REST: min_rest = val;
                CFG_MAX_REST: max_rest = val;
                default: ;
            endcase
        endfunction

        function void clear_run();
            phase      = PH_IDLE;
            raw_firing = '0;
            raw_hold   = '0;
            foreach (raw_fire_dl[i]) raw_fire_dl[i] = '0;
            foreach (raw_rest_dl[i]) raw_rest_dl[i] = '0;
        endfunction

        function logic [2:0] step_move(logic [2:0] idx, logic back);
            return back ? idx + 3'd7 : idx + 3'd1;
        endfunction

        function logic [15:0] chase_pattern(t_chase c, logic [3:0] mode);
            logic [15:0] p;
            if (mode == MODE_ALL) return PAT_ALL;
            if (mode == MODE_ALT) return (step_idx != 3'd0) ? PAT_ODD : PAT_EVEN;
            p = 16'd1 << step_idx;
            if (c.mirrored) p |= 16'd1 << (3'd7 - step_idx);
            return p;
        endfunction

        function void start_cycle(t_chase c, logic [31:0] now, logic [15:0] fire);
            step_idx  = c.first;
            step_back = c.backward;
            phase     = PH_FIRE;
            phase_dl  = now + fire;
        endfunction

        // Move to the next step after a rest; a one-shot parks in done.
        function void advance(t_chase c, logic rep, logic [31:0] now, logic [15:0] fire);
            if (!c.bounce) begin
                if (step_idx == c.last) begin
                    if (!rep) begin
                        phase = PH_DONE;
                        return;
                    end
                    step_idx = c.first;
                end else begin
                    step_idx = step_move(step_idx, step_back);
                end
            end else if (step_idx == c.last && step_back == c.backward) begin
                step_back = !c.backward;
                step_idx  = step_move(step_idx, step_back);
            end else if (step_idx == c.first && step_back != c.backward) begin
                if (!rep) begin
                    phase = PH_DONE;
                    return;
                end
                step_back = c.backward;
                step_idx  = step_move(step_idx, step_back);
            end else begin
                step_idx = step_move(step_idx, step_back);
            end
            phase    = PH_FIRE;
            phase_dl = now + fire;
        endfunction

        // Advance the shadow state by one accepted tick and queue its mask.
        function void note_tick(tick_t t);
            t_chase      c;
            logic [15:0] fire, rest, mask;
            logic [31:0] r;
            logic        want;
            if (t.mode != cur_mode) begin
                clear_run();
                cur_mode = t.mode;
            end
            fire = clamp_ms(32'(t.fire_ms), min_fire, max_fire);
            r = 32'(clamp_ms(32'(t.rest_ms), min_rest, max_rest));
            r = r * (32'd256 - t.rate) / 32'd128;
            if (r > 32'h0000_FFFF) r = 32'h0000_FFFF;
            rest = clamp_ms(r, min_rest, max_rest);
            mask = '0;
            if (t.mode == MODE_RAW) begin
                for (int i = 0; i < N_OUT; i++) begin
                    want = t.trig[i];
                    if (raw_firing[i]) begin
                        if (!want || deadline_hit(raw_fire_dl[i], t.now_ms)) begin
                            raw_firing[i]  = 1'b0;
                            raw_rest_dl[i] = t.now_ms + rest;
                            if (want && !t.rep) raw_hold[i] = 1'b1;
                        end
                    end else if (!want) begin
                        raw_hold[i] = 1'b0;
                    end else if (!raw_hold[i] && deadline_hit(raw_rest_dl[i], t.now_ms)) begin
                        raw_firing[i]  = 1'b1;
                        raw_fire_dl[i] = t.now_ms + fire;
                    end
                end
                mask = 16'(raw_firing);
            end else if (t.mode >= MODE_UP && t.mode <= MODE_ALT) begin
                c = chase_of(t.mode);
                case (phase)
                    PH_IDLE: start_cycle(c, t.now_ms, fire);
                    PH_FIRE: begin
                        if (deadline_hit(phase_dl, t.now_ms)) begin
                            phase    = PH_REST;
                            phase_dl = t.now_ms + rest;
                        end
                    end
                    PH_REST: begin
                        if (deadline_hit(phase_dl, t.now_ms)) advance(c, t.rep, t.now_ms, fire);
                    end
                    default: begin
                        if (t.rep) start_cycle(c, t.now_ms, fire);
                    end
                endcase
                if (phase == PH_FIRE) mask = chase_pattern(c, t.mode) & t.trig;
            end
            expected_masks.push_back(mask);
        endfunction

        function void check_mask(logic [15:0] got);
            logic [15:0] exp_mask;
            if (expected_masks.size() == 0) begin
                $error("fire_mask: expected none pending, actual 0x%04h", got);
                errors++;
                return;
            end
            exp_mask = expected_masks.pop_front();
            if (got !== exp_mask) begin
                $error("fire_mask: expected 0x%04h, actual 0x%04h", exp_mask, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_masks.size();
        endfunction
    endclass

endpackage

FILE: test/output_chase_pattern_sequencer_tb.sv
`timescale 1ns / 1ps
// Testbench for output_chase_pattern_sequencer: directed and random ticks under
// several clamp settings, with the fire_mask_board scoreboard from ocps_tb_pkg.
module output_chase_pattern_sequencer_tb;
    import ocps_pkg::*;
    import ocps_tb_pkg::*;

    localparam int IDLE_PCT        = 36;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_MIN_FIRE;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [3:0]  i_mode = MODE_OFF;
    logic [15:0] i_trigger_mask = '0;
    logic        i_repeat_req = 1'b0;
    logic [15:0] i_fire_ms = '0;
    logic [15:0] i_rest_ms = '0;
    logic [7:0]  i_rate = '0;
    logic [31:0] i_now_ms = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_fire_mask;

    fire_mask_board board;
    logic [31:0]    now_cursor = '0;
    bit             no_gaps = 1'b0;      // both sides stream without idle cycles
    bit             hold_off_req = 1'b0; // receiver stalls for a long stretch

    output_chase_pattern_sequencer #(
        .NUM_OUTPUTS(N_OUT)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_mode(i_mode),
        .i_trigger_mask(i_trigger_mask),
        .i_repeat_req(i_repeat_req),
        .i_fire_ms(i_fire_ms),
        .i_rest_ms(i_rest_ms),
        .i_rate(i_rate),
        .i_now_ms(i_now_ms),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_fire_mask(o_fire_mask)
    );

    always #5 i_clk = ~i_clk;

    // Offer one tick and hold it until the input transaction completes.
    // Called right after a rising edge; inputs read here still hold pre-edge values.
    task automatic send_tick(input tick_t t);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= t.mode;
        i_trigger_mask <= t.trig;
        i_repeat_req   <= t.rep;
        i_fire_ms      <= t.fire_ms;
        i_rest_ms      <= t.rest_ms;
        i_rate         <= t.rate;
        i_now_ms       <= t.now_ms;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_tick(t);
    endtask

    // Advance the clock in ms by dnow, then send a tick at the new time.
    task automatic send_update(input logic [3:0] mode, input logic [15:0] trig, input logic rep,
                               input logic [15:0] fire_ms, input logic [15:0] rest_ms,
                               input logic [7:0] rate, input logic [31:0] dnow);
        tick_t t;
        now_cursor += dnow;
        t = '{mode: mode, trig: trig, rep: rep, fire_ms: fire_ms, rest_ms: rest_ms,
              rate: rate, now_ms: now_cursor};
        send_tick(t);
    endtask

    // Drop valid and wait until every queued mask has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four clamp registers, one per cycle, while the block is idle.
    task automatic write_clamps(input logic [15:0] fmin, input logic [15:0] fmax,
                                input logic [15:0] rmin, input logic [15:0] rmax);
        logic [1:0]  idx [4];
        logic [15:0] val [4];
        idx = '{CFG_MIN_FIRE, CFG_MAX_FIRE, CFG_MIN_REST, CFG_MAX_REST};
        val = '{fmin, fmax, rmin, rmax};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            board.set_reg(idx[k], val[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_ms(int span);
        int r;
        r = $urandom_range(99);
        if (r < 5) return 16'd0;
        if (r < 10) return 16'hFFFF;
        if (r < 15) return 16'($urandom);
        return 16'($urandom_range(0, (span > 65535) ? 65535 : span));
    endfunction

    function automatic logic [7:0] pick_rate();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 8'd0;
        if (r < 20) return 8'hFF;
        if (r < 35) return 8'd128;
        return 8'($urandom);
    endfunction

    function automatic logic [31:0] pick_step(int span);
        int r;
        r = $urandom_range(99);
        if (r < 5) return 32'd0;
        if (r < 9) return $urandom;
        return 32'($urandom_range(0, span));
    endfunction

    // Random runs: hold a mode for a stretch of ticks with mostly steady fields so
    // the chase walks through its steps; sprinkle in mode glitches and field changes.
    task automatic run_random(input int n_items, input int span);
        int          sent;
        int          run_len;
        int          r;
        logic [3:0]  run_mode;
        logic [15:0] trig, fire, rest;
        logic        rep;
        logic [7:0]  rate;
        logic [3:0]  mode;
        sent = 0;
        now_cursor = $urandom;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 6) run_mode = MODE_OFF;
            else if (r < 10) run_mode = 4'($urandom_range(12, 15));
            else if (r < 35) run_mode = MODE_RAW;
            else run_mode = 4'($urandom_range(MODE_UP, MODE_ALT));
            trig = ($urandom_range(99) < 30) ? 16'hFFFF : 16'($urandom);
            rep  = 1'($urandom);
            fire = pick_ms(span);
            rest = pick_ms(span);
            rate = pick_rate();
            run_len = $urandom_range(6, 40);
            for (int k = 0; k < run_len && sent < n_items; k++) begin
                mode = ($urandom_range(99) < 4) ? 4'($urandom) : run_mode;
                if (run_mode == MODE_RAW)
                    trig ^= 16'($urandom) & 16'($urandom) & 16'($urandom);
                else if ($urandom_range(99) < 10)
                    trig = 16'($urandom);
                if ($urandom_range(99) < 10) rep = !rep;
                if ($urandom_range(99) < 10) fire = pick_ms(span);
                if ($urandom_range(99) < 10) rest = pick_ms(span);
                if ($urandom_range(99) < 10) rate = pick_rate();
                send_update(mode, trig, rep, fire, rest, rate, pick_step(span));
                sent++;
            end
        end
    endtask

    // Result side: check each completed output transaction, then pick the next ready.
    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) board.check_mask(o_fire_mask);
            if (hold_off_req) begin
                // Hold off long enough for the queue to fill and stall the input.
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            i_out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Abort when nothing moves on any port for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks under the reset clamps.
        now_cursor = 32'd1000;
        // off and unknown modes give nothing, whatever the fields say
        send_update(MODE_OFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 32'd0);
        send_update(4'd15, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 32'd0);
        send_update(4'd12, 16'hFFFF, 1'b0, 16'd0, 16'd0, 8'd0, 32'd0);
        // all mode as a one-shot: fire, rest, done, stay done, restart on repeat
        send_update(MODE_ALL, 16'hFFFF, 1'b0, 16'd0, 16'd0, 8'd0, 32'd5);
        send_update(MODE_ALL, 16'hFFFF, 1'b0, 16'd0, 16'd0, 8'd0, 32'd20);
        send_update(MODE_ALL, 16'hFFFF, 1'b0, 16'd0, 16'd0, 8'd0, 32'd40);
        send_update(MODE_ALL, 16'hFFFF, 1'b0, 16'd0, 16'd0, 8'd0, 32'd100);
        send_update(MODE_ALL, 16'h8001, 1'b1, 16'd0, 16'd0, 8'd0, 32'd1);
        // alternate pattern, rest clamped from the top
        send_update(MODE_ALT, 16'hFFFF, 1'b1, 16'd0, 16'hFFFF, 8'd128, 32'd0);
        send_update(MODE_ALT, 16'hFFFF, 1'b1, 16'd0, 16'hFFFF, 8'd128, 32'd20);
        send_update(MODE_ALT, 16'hFFFF, 1'b1, 16'd0, 16'hFFFF, 8'd128, 32'd5000);
        // bounce and mirrored starts, fastest tempo
        send_update(MODE_UPDOWN, 16'hFFFF, 1'b0, 16'hFFFF, 16'd0, 8'hFF, 32'd0);
        send_update(MODE_OUTIN, 16'hFFFF, 1'b0, 16'hFFFF, 16'd0, 8'hFF, 32'd0);
        // raw: fire, expire into need-release, release, refire, held retrigger
        send_update(MODE_RAW, 16'hFFFF, 1'b0, 16'd0, 16'd0, 8'd0, 32'd0);
        send_update(MODE_RAW, 16'hFFFF, 1'b0, 16'd0, 16'd0, 8'd0, 32'd20);
        send_update(MODE_RAW, 16'hFFFF, 1'b0, 16'd0, 16'd0, 8'd0, 32'd100);
        send_update(MODE_RAW, 16'h0000, 1'b0, 16'd0, 16'd0, 8'd0, 32'd1);
        send_update(MODE_RAW, 16'h00AA, 1'b0, 16'd0, 16'd0, 8'd0, 32'd1);
        send_update(MODE_RAW, 16'h0000, 1'b1, 16'd0, 16'd0, 8'd0, 32'd1);
        send_update(MODE_RAW, 16'h00AA, 1'b1, 16'd0, 16'd0, 8'd0, 32'd1);
        send_update(MODE_RAW, 16'h00AA, 1'b1, 16'd0, 16'd0, 8'd0, 32'd50);
        send_update(MODE_RAW, 16'h00AA, 1'b1, 16'd0, 16'd0, 8'd0, 32'd20);
        send_update(MODE_RAW, 16'h00AA, 1'b1, 16'd0, 16'd0, 8'd0, 32'd40);
        // time jumps across the half-range comparison boundary
        send_update(MODE_UP, 16'hFFFF, 1'b1, 16'd0, 16'd0, 8'd0, 32'h8000_0000);
        send_update(MODE_UP, 16'hFFFF, 1'b1, 16'd0, 16'd0, 8'd0, 32'h7FFF_FFFF);
        wait_drained();

        // Reset clamps, with one long receiver stall in the middle.
        run_random(60, 80);
        hold_off_req = 1'b1;
        run_random(140, 80);
        wait_drained();

        // Tight clamps so phases turn over every few ticks; start with a gap-free stretch.
        write_clamps(16'd1, 16'd12, 16'd0, 16'd10);
        no_gaps = 1'b1;
        run_random(150, 12);
        no_gaps = 1'b0;
        run_random(100, 12);
        wait_drained();

        // Low extreme: every duration collapses to zero.
        write_clamps(16'd0, 16'd0, 16'd0, 16'd0);
        run_random(150, 3);
        wait_drained();

        // High extreme: every duration pinned at the maximum.
        write_clamps(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(150, 40000);
        wait_drained();

        // Inverted bounds, plus a second long stall.
        write_clamps(16'd30, 16'd5, 16'd40, 16'd3);
        hold_off_req = 1'b1;
        run_random(200, 40);
        wait_drained();

        // Random small bounds.
        write_clamps(16'($urandom_range(0, 20)), 16'($urandom_range(5, 60)),
                     16'($urandom_range(0, 20)), 16'($urandom_range(5, 60)));
        run_random(200, 50);
        wait_drained();

        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
